@@ sv/deadline_callback_queue_assert.svh @@
// Assertion macros used by the checker of the deadline callback queue.
`ifndef DEADLINE_CALLBACK_QUEUE_ASSERT_SVH
`define DEADLINE_CALLBACK_QUEUE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define DCQ_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define DCQ_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

@@ sv/dcq_pkg.sv @@
`default_nettype none
package dcq_pkg;

   localparam int TIME_W      = 32;
   localparam int MAX_RESULTS = 16;
   localparam int RESULT_CW   = $clog2(MAX_RESULTS + 1);

   typedef enum logic {
      OP_SCHEDULE = 1'b0,
      OP_SERVICE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RES_ACCEPTED = 2'd0,
      RES_REJECTED = 2'd1,
      RES_DUE      = 2'd2
   } result_kind_type;

   typedef enum logic {
      CMP_DUE   = 1'b0,   // stored deadline strictly earlier than key
      CMP_AFTER = 1'b1    // stored deadline strictly later than key
   } cmp_mode_type;

   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] handle;
      logic [TIME_W-1:0] arg;
      logic [TIME_W-1:0] deadline;
   } entry_type;

endpackage
`default_nettype wire

@@ sv/dcq_ram.sv @@
`default_nettype none
module dcq_ram
   import dcq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type wr_data,
   input  wire logic      rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type      rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/dcq_cmp.sv @@
`default_nettype none
module dcq_cmp
   import dcq_pkg::*;
(
   input  wire cmp_mode_type       mode,
   input  wire logic [TIME_W-1:0]  entry_deadline,
   input  wire logic [TIME_W-1:0]  key,
   output logic                    hit
);

   logic [TIME_W-1:0] lhs;
   logic [TIME_W-1:0] rhs;
   logic [TIME_W:0]   diff;

   always_comb begin
      case (mode)
         CMP_DUE: begin
            lhs = entry_deadline;
            rhs = key;
         end
         CMP_AFTER: begin
            lhs = key;
            rhs = entry_deadline;
         end
         default: begin
            lhs = entry_deadline;
            rhs = key;
         end
      endcase
   end

   // borrow out of the subtract means lhs < rhs
   assign diff = {1'b0, lhs} - {1'b0, rhs};
   assign hit  = diff[TIME_W];

endmodule
`default_nettype wire

@@ sv/deadline_callback_queue.sv @@
// Channel   Ports                            Transaction
// request   start, busy, req_*               taken when start is high and busy is low
// response  rsp_strobe, rsp_*                one cycle per result, always taken
//
// Entries sit in a ring in one single-port-read RAM, kept in deadline order.
// Schedule: each entry with a later deadline moves up one slot; an empty or full store needs no
// compare, else one compare per cycle, limited by the RAM read port.
// Service: at most 16 due entries per request.
// Reset clears the entry count and ring head; no clearing pass over the RAM.
// Results cannot be stalled; busy stays high until the last one is issued.
`default_nettype none
module deadline_callback_queue
   import dcq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_operation,
   input  wire logic [TIME_W-1:0]  req_current_time,
   input  wire logic [TIME_W-1:0]  req_delay,
   input  wire logic               req_callback_kind,
   input  wire logic [TIME_W-1:0]  req_callback_ref,
   input  wire logic [TIME_W-1:0]  req_callback_arg,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_result_kind,
   output logic                    rsp_due_kind,
   output logic [TIME_W-1:0]       rsp_due_ref,
   output logic [TIME_W-1:0]       rsp_due_arg,
   output logic [TIME_W-1:0]       rsp_due_deadline,
   output logic                    rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
   localparam logic [AW:0]   CAP_W    = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
   localparam logic [RESULT_CW-1:0] LAST_RESULT = RESULT_CW'(MAX_RESULTS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_LAST,
      S_SRV_CMP
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic [RESULT_CW-1:0]    n_ff, n_in;
   logic                    flush_ff, flush_in;
   entry_type               new_ff, new_in;
   entry_type               pend_ff, pend_in;
   logic                    strobe_ff, strobe_in;
   result_kind_type         rkind_ff, rkind_in;
   entry_type               rdue_ff, rdue_in;
   logic                    rlast_ff, rlast_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   entry_type               wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   entry_type               rd_data;

   cmp_mode_type            cmp_mode;
   logic                    cmp_hit;

   logic [TIME_W:0]         sched_sum;
   logic [TIME_W-1:0]       sched_dl;
   logic [AW:0]             tail_sum;
   logic [AW-1:0]           tail_last;
   logic [AW-1:0]           ptr_inc;
   logic [AW-1:0]           ptr_dec;
   logic [AW-1:0]           head_inc;
   logic                    accept;

   dcq_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dcq_cmp u_cmp (
      .mode           (cmp_mode),
      .entry_deadline (rd_data.deadline),
      .key            (new_ff.deadline),
      .hit            (cmp_hit)
   );

   // hold off new transactions while the held due entry drains
   assign busy      = (state_ff != S_IDLE) || flush_ff;
   assign accept    = start && !busy;
   assign cmp_mode  = (state_ff == S_SRV_CMP) ? CMP_DUE : CMP_AFTER;

   // saturate the deadline at the top of the time range
   assign sched_sum = {1'b0, req_current_time} + {1'b0, req_delay};
   assign sched_dl  = sched_sum[TIME_W] ? '1 : sched_sum[TIME_W-1:0];

   // ring slot of the newest entry; only used while count is nonzero
   assign tail_sum  = {1'b0, head_ff} + (AW + 1)'(count_ff - 1'b1);
   assign tail_last = (tail_sum >= CAP_W) ? AW'(tail_sum - CAP_W) : tail_sum[AW-1:0];

   assign ptr_inc   = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
   assign ptr_dec   = (ptr_ff == '0) ? LAST_IDX : ptr_ff - 1'b1;
   assign head_inc  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      n_in      = n_ff;
      flush_in  = 1'b0;
      new_in    = new_ff;
      pend_in   = pend_ff;
      strobe_in = 1'b0;
      rkind_in  = rkind_ff;
      rdue_in   = rdue_ff;
      rlast_in  = rlast_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_inc;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = head_ff;

      case (state_ff)
         S_IDLE: begin
            // drain the held due entry once the sequence has ended
            if (flush_ff) begin
               strobe_in = 1'b1;
               rkind_in  = RES_DUE;
               rdue_in   = pend_ff;
               rlast_in  = 1'b1;
            end
            if (accept) begin
               new_in.kind   = req_callback_kind;
               new_in.handle = req_callback_ref;
               new_in.arg    = req_callback_arg;
               if (req_operation == OP_SCHEDULE) begin
                  new_in.deadline = sched_dl;
                  if (count_ff == FULL_CNT) begin
                     strobe_in = 1'b1;
                     rkind_in  = RES_REJECTED;
                     rdue_in   = '0;
                     rlast_in  = 1'b1;
                  end else if (count_ff == '0) begin
                     wr_en     = 1'b1;
                     wr_addr   = head_ff;
                     wr_data   = new_in;
                     count_in  = count_ff + 1'b1;
                     strobe_in = 1'b1;
                     rkind_in  = RES_ACCEPTED;
                     rdue_in   = '0;
                     rlast_in  = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = tail_last;
                     ptr_in   = tail_last;
                     rem_in   = count_ff;
                     state_in = S_INS_CMP;
                  end
               end else begin
                  new_in.deadline = req_current_time;
                  if (count_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     n_in     = '0;
                     state_in = S_SRV_CMP;
                  end
               end
            end
         end

         S_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_inc;
            if (cmp_hit) begin
               // stored entry is later: move it up one slot
               wr_data = rd_data;
               if (rem_ff == CW'(1)) begin
                  state_in = S_INS_LAST;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec;
                  ptr_in  = ptr_dec;
                  rem_in  = rem_ff - 1'b1;
               end
            end else begin
               wr_data   = new_ff;
               count_in  = count_ff + 1'b1;
               strobe_in = 1'b1;
               rkind_in  = RES_ACCEPTED;
               rdue_in   = '0;
               rlast_in  = 1'b1;
               state_in  = S_IDLE;
            end
         end

         S_INS_LAST: begin
            wr_en     = 1'b1;
            wr_addr   = ptr_ff;
            wr_data   = new_ff;
            count_in  = count_ff + 1'b1;
            strobe_in = 1'b1;
            rkind_in  = RES_ACCEPTED;
            rdue_in   = '0;
            rlast_in  = 1'b1;
            state_in  = S_IDLE;
         end

         S_SRV_CMP: begin
            if (cmp_hit) begin
               // hold this entry until the next compare, or the end of the burst, tells whether it is last
               if (n_ff != '0) begin
                  strobe_in = 1'b1;
                  rkind_in  = RES_DUE;
                  rdue_in   = pend_ff;
                  rlast_in  = 1'b0;
               end
               pend_in  = rd_data;
               n_in     = n_ff + 1'b1;
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
               if ((n_ff == LAST_RESULT) || (count_ff == CW'(1))) begin
                  flush_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = head_inc;
               end
            end else begin
               if (n_ff != '0) begin
                  strobe_in = 1'b1;
                  rkind_in  = RES_DUE;
                  rdue_in   = pend_ff;
                  rlast_in  = 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         head_ff   <= '0;
         flush_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         head_ff   <= head_in;
         flush_ff  <= flush_in;
         strobe_ff <= strobe_in;
      end
      ptr_ff   <= ptr_in;
      rem_ff   <= rem_in;
      n_ff     <= n_in;
      new_ff   <= new_in;
      pend_ff  <= pend_in;
      rkind_ff <= rkind_in;
      rdue_ff  <= rdue_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_kind  = rkind_ff;
   assign rsp_due_kind     = rdue_ff.kind;
   assign rsp_due_ref      = rdue_ff.handle;
   assign rsp_due_arg      = rdue_ff.arg;
   assign rsp_due_deadline = rdue_ff.deadline;
   assign rsp_last         = rlast_ff;

endmodule
`default_nettype wire

@@ sv/dcq_checker.sv @@
`default_nettype none
`include "deadline_callback_queue_assert.svh"
module dcq_checker
   import dcq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic               rsp_strobe,
   input  wire logic [1:0]         rsp_result_kind,
   input  wire logic               rsp_due_kind,
   input  wire logic [TIME_W-1:0]  rsp_due_ref,
   input  wire logic [TIME_W-1:0]  rsp_due_arg,
   input  wire logic [TIME_W-1:0]  rsp_due_deadline,
   input  wire logic               rsp_last
);

   logic              sched_rsp;
   logic              sched_zero;
   logic              due_rsp;
   logic              due_more;
   logic              due_order;
   logic              req_accept;
   logic [TIME_W-1:0] prev_deadline_ff;

   assign sched_rsp  = rsp_strobe && (rsp_result_kind != RES_DUE);
   assign sched_zero = (rsp_due_kind == 1'b0) && (rsp_due_ref == '0) && (rsp_due_arg == '0)
                       && (rsp_due_deadline == '0);
   assign due_rsp    = rsp_strobe && (rsp_result_kind == RES_DUE);
   assign due_more   = due_rsp && !rsp_last;
   assign due_order  = rsp_due_deadline >= prev_deadline_ff;
   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      prev_deadline_ff <= rsp_due_deadline;
   end

   `DCQ_ASSERT_SAME(a_sched_last, clock, reset, sched_rsp, rsp_last, "schedule answer not last")
   `DCQ_ASSERT_SAME(a_sched_zero, clock, reset, sched_rsp, sched_zero, "payload not zero")
   `DCQ_ASSERT_NEXT(a_due_burst, clock, reset, due_more, due_rsp, "due burst broken")
   `DCQ_ASSERT_NEXT(a_due_order, clock, reset, due_more, due_order, "due out of order")
   `DCQ_ASSERT_NEXT(a_accept_quiet, clock, reset, req_accept, !due_rsp, "due after accept")

endmodule

bind deadline_callback_queue dcq_checker u_dcq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_due_kind     (rsp_due_kind),
   .rsp_due_ref      (rsp_due_ref),
   .rsp_due_arg      (rsp_due_arg),
   .rsp_due_deadline (rsp_due_deadline),
   .rsp_last         (rsp_last)
);
`default_nettype wire
